// ===== rtl/jsu_pkg.sv =====
// Shared types, codes and helper function of the JSON string unescaper.
`default_nettype none
package jsu_pkg;

    // Width of the saturating decoded byte counter.
    localparam int unsigned LENGTH_BITS = 16;
    localparam int unsigned LEN_OUT_W   = 16;
    localparam int unsigned MAX_RESULTS = 4;

    // Characters of interest.
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_BSLSH = 8'h5C;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_LO_B  = 8'h62;
    localparam logic [7:0] CH_LO_F  = 8'h66;
    localparam logic [7:0] CH_LO_N  = 8'h6E;
    localparam logic [7:0] CH_LO_R  = 8'h72;
    localparam logic [7:0] CH_LO_T  = 8'h74;
    localparam logic [7:0] CH_LO_U  = 8'h75;
    localparam logic [7:0] CH_SPACE = 8'h20;

    localparam logic [15:0] HI_SURR_MIN = 16'hD800;
    localparam logic [15:0] HI_SURR_MAX = 16'hDBFF;
    localparam logic [15:0] LO_SURR_MIN = 16'hDC00;
    localparam logic [15:0] LO_SURR_MAX = 16'hDFFF;
    localparam logic [20:0] SUPP_BASE   = 21'h10000;
    localparam logic [20:0] CP_MAX_1B   = 21'h00007F;
    localparam logic [20:0] CP_MAX_2B   = 21'h0007FF;
    localparam logic [20:0] CP_MAX_3B   = 21'h00FFFF;

    typedef enum logic [3:0] {
        MODE_IDLE    = 4'd0,
        MODE_TEXT    = 4'd1,
        MODE_ESC     = 4'd2,
        MODE_HEX     = 4'd3,
        MODE_LOW_BS  = 4'd4,
        MODE_LOW_U   = 4'd5,
        MODE_LOW_HEX = 4'd6
    } t_mode;

    typedef enum logic [2:0] {
        ST_DATA       = 3'd0,
        ST_END        = 3'd1,
        ST_NO_QUOTE   = 3'd2,
        ST_BAD_ESC    = 3'd3,
        ST_BAD_HEX    = 3'd4,
        ST_BAD_SURR   = 3'd5,
        ST_BAD_CHAR   = 3'd6,
        ST_NOT_STRING = 3'd7
    } t_status;

    // Hex digit decode: bit 4 flags a valid digit, bits 3:0 carry its value.
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b1, c[3:0]};
        end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
            r = {1'b1, c[3:0] + 4'd9};
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/json_string_unescape_utf8.sv =====
// JSON string unescaper: bytes of JSON text in, UTF-8 string bytes and status out.
//
// One JSON text byte enters per input beat; a byte that yields one result or none is
// taken every cycle unless stalled. Decoding, escape handling and UTF-8 encoding sit
// between the input handshake and a four-entry result register draining one
// beat per cycle unless stalled, so a \uXXXX escape holds input as it drains. Output
// tdata is {string_length[15:0], out_byte[7:0]}, tuser is {status[2:0], has_byte},
// tlast marks the final beat caused by one input byte. On any error status the string
// ends and the block waits for a new opening quote; drop the data already received.
`default_nettype none
module json_string_unescape_utf8
    import jsu_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [7:0]  i_s_axis_tdata,   // [7:0] in_byte
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic [23:0]      o_m_axis_tdata,   // [7:0] out_byte, [23:8] string_length
    output logic [3:0]       o_m_axis_tuser,   // [0] has_byte, [3:1] status
    output logic             o_m_axis_tlast
);

    t_mode                  r_mode, n_mode;
    logic [15:0]            r_acc, n_acc;
    logic [1:0]             r_dcnt, n_dcnt;
    logic [9:0]             r_hs, n_hs;
    logic [LENGTH_BITS-1:0] r_bc, n_bc;

    logic [7:0]             r_obyte [MAX_RESULTS];
    logic [2:0]             r_ocnt;
    logic [1:0]             r_oidx;
    logic                   r_oend;
    t_status                r_ostatus;
    logic [LEN_OUT_W-1:0]   r_olen;

    logic                   in_acc, out_acc;
    logic [7:0]             c;
    logic [4:0]             hv;
    logic [15:0]            acc_sh;
    logic [20:0]            pair_cp;
    logic                   enc;
    logic [20:0]            enc_cp;
    logic [2:0]             em_n;
    logic                   em_end;
    t_status                em_status;
    logic [LEN_OUT_W-1:0]   em_len;
    logic [7:0]             em_byte [MAX_RESULTS];
    logic [LENGTH_BITS:0]   bc_sum;
    logic [LENGTH_BITS+LEN_OUT_W-1:0] bc_wide;

    assign c        = i_s_axis_tdata;
    assign hv       = hex_digit(c);
    assign acc_sh   = {r_acc[11:0], hv[3:0]};
    assign pair_cp  = {1'b0, r_hs, acc_sh[9:0]} + SUPP_BASE;
    assign bc_wide  = {{LEN_OUT_W{1'b0}}, r_bc};

    assign o_s_axis_tready = (r_ocnt == 3'd0) || (r_ocnt == 3'd1 && i_m_axis_tready);
    assign in_acc          = i_s_axis_tvalid && o_s_axis_tready;
    assign out_acc         = o_m_axis_tvalid && i_m_axis_tready;

    always_comb begin
        n_mode    = r_mode;
        n_acc     = r_acc;
        n_dcnt    = r_dcnt;
        n_hs      = r_hs;
        n_bc      = r_bc;
        enc       = 1'b0;
        enc_cp    = 21'd0;
        em_n      = 3'd0;
        em_end    = 1'b0;
        em_status = ST_DATA;
        em_len    = '0;
        em_byte[0] = c;
        em_byte[1] = 8'd0;
        em_byte[2] = 8'd0;
        em_byte[3] = 8'd0;

        unique case (r_mode)
            MODE_TEXT: begin
                if (c == CH_QUOTE) begin
                    em_end    = 1'b1;
                    em_status = ST_END;
                    em_len    = bc_wide[LEN_OUT_W-1:0];
                end else if (c == CH_NUL) begin
                    em_end    = 1'b1;
                    em_status = ST_NO_QUOTE;
                end else if (c == CH_BSLSH) begin
                    n_mode = MODE_ESC;
                end else if (c < CH_SPACE) begin
                    em_end    = 1'b1;
                    em_status = ST_BAD_CHAR;
                end else begin
                    em_n = 3'd1;
                end
            end
            MODE_ESC: begin
                n_mode = MODE_TEXT;
                em_n   = 3'd1;
                unique case (c)
                    CH_QUOTE, CH_BSLSH, CH_SLASH: em_byte[0] = c;
                    CH_LO_B: em_byte[0] = 8'h08;
                    CH_LO_F: em_byte[0] = 8'h0C;
                    CH_LO_N: em_byte[0] = 8'h0A;
                    CH_LO_R: em_byte[0] = 8'h0D;
                    CH_LO_T: em_byte[0] = 8'h09;
                    CH_LO_U: begin
                        em_n   = 3'd0;
                        n_mode = MODE_HEX;
                        n_acc  = 16'd0;
                        n_dcnt = 2'd0;
                    end
                    default: begin
                        em_n      = 3'd0;
                        em_end    = 1'b1;
                        em_status = ST_BAD_ESC;
                    end
                endcase
            end
            MODE_HEX, MODE_LOW_HEX: begin
                if (!hv[4]) begin
                    em_end    = 1'b1;
                    em_status = ST_BAD_HEX;
                end else begin
                    n_acc = acc_sh;
                    if (r_dcnt != 2'd3) begin
                        n_dcnt = r_dcnt + 2'd1;
                    end else begin
                        n_dcnt = 2'd0;
                        if (r_mode == MODE_HEX) begin
                            if (acc_sh >= HI_SURR_MIN && acc_sh <= HI_SURR_MAX) begin
                                n_hs   = acc_sh[9:0];
                                n_mode = MODE_LOW_BS;
                            end else begin
                                n_mode = MODE_TEXT;
                                enc    = 1'b1;
                                enc_cp = {5'd0, acc_sh};
                            end
                        end else if (acc_sh < LO_SURR_MIN || acc_sh > LO_SURR_MAX) begin
                            em_end    = 1'b1;
                            em_status = ST_BAD_SURR;
                        end else begin
                            n_mode = MODE_TEXT;
                            enc    = 1'b1;
                            enc_cp = pair_cp;
                        end
                    end
                end
            end
            MODE_LOW_BS: begin
                if (c == CH_BSLSH) begin
                    n_mode = MODE_LOW_U;
                end else begin
                    em_end    = 1'b1;
                    em_status = ST_BAD_SURR;
                end
            end
            MODE_LOW_U: begin
                if (c == CH_LO_U) begin
                    n_mode = MODE_LOW_HEX;
                    n_acc  = 16'd0;
                    n_dcnt = 2'd0;
                end else begin
                    em_end    = 1'b1;
                    em_status = ST_BAD_SURR;
                end
            end
            default: begin
                if (c == CH_QUOTE) begin
                    n_mode = MODE_TEXT;
                    n_bc   = '0;
                    n_acc  = 16'd0;
                    n_dcnt = 2'd0;
                end else begin
                    em_end    = 1'b1;
                    em_status = ST_NOT_STRING;
                end
            end
        endcase

        if (enc) begin
            if (enc_cp <= CP_MAX_1B) begin
                em_n       = 3'd1;
                em_byte[0] = enc_cp[7:0];
            end else if (enc_cp <= CP_MAX_2B) begin
                em_n       = 3'd2;
                em_byte[0] = {3'b110, enc_cp[10:6]};
                em_byte[1] = {2'b10, enc_cp[5:0]};
            end else if (enc_cp <= CP_MAX_3B) begin
                em_n       = 3'd3;
                em_byte[0] = {4'b1110, enc_cp[15:12]};
                em_byte[1] = {2'b10, enc_cp[11:6]};
                em_byte[2] = {2'b10, enc_cp[5:0]};
            end else begin
                em_n       = 3'd4;
                em_byte[0] = {5'b11110, enc_cp[20:18]};
                em_byte[1] = {2'b10, enc_cp[17:12]};
                em_byte[2] = {2'b10, enc_cp[11:6]};
                em_byte[3] = {2'b10, enc_cp[5:0]};
            end
        end

        // Saturate the decoded length at all ones.
        bc_sum = {1'b0, r_bc} + {{(LENGTH_BITS-2){1'b0}}, em_n};
        if (em_n != 3'd0) begin
            n_bc = bc_sum[LENGTH_BITS] ? {LENGTH_BITS{1'b1}} : bc_sum[LENGTH_BITS-1:0];
        end
        if (em_end) begin
            n_mode = MODE_IDLE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_IDLE;
            r_acc  <= 16'd0;
            r_dcnt <= 2'd0;
            r_hs   <= 10'd0;
            r_bc   <= '0;
        end else if (in_acc) begin
            r_mode <= n_mode;
            r_acc  <= n_acc;
            r_dcnt <= n_dcnt;
            r_hs   <= n_hs;
            r_bc   <= n_bc;
        end
    end

    // Result register: load on a producing beat, advance one entry per output beat.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ocnt <= 3'd0;
            r_oidx <= 2'd0;
        end else if (in_acc && (em_end || em_n != 3'd0)) begin
            r_ocnt <= em_end ? 3'd1 : em_n;
            r_oidx <= 2'd0;
        end else if (out_acc) begin
            r_ocnt <= r_ocnt - 3'd1;
            r_oidx <= r_oidx + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && (em_end || em_n != 3'd0)) begin
            r_obyte   <= em_byte;
            r_oend    <= em_end;
            r_ostatus <= em_status;
            r_olen    <= em_len;
        end
    end

    assign o_m_axis_tvalid = (r_ocnt != 3'd0);
    assign o_m_axis_tlast  = (r_ocnt == 3'd1);
    assign o_m_axis_tdata  = {r_olen, r_oend ? 8'd0 : r_obyte[r_oidx]};
    assign o_m_axis_tuser  = {r_ostatus, !r_oend};

`ifndef SYNTHESIS
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ocnt <= 3'd4)
        else $error("result count above four");

    a_end_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !o_m_axis_tuser[0]) |-> o_m_axis_tlast)
        else $error("end result not on final beat");

    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_s_axis_tready |-> (r_ocnt <= 3'd1))
        else $error("input ready while results pending");

    a_len_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && !($past(in_acc) && $past(r_mode) == MODE_IDLE))
        |-> (r_bc >= $past(r_bc)))
        else $error("byte count dropped inside a string");

    a_data_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser[0]) |-> (o_m_axis_tuser[3:1] == ST_DATA))
        else $error("data beat with non-data status");
`endif

endmodule
`default_nettype wire

// ===== tb/sv/tb_json_string_unescape_utf8.sv =====
// Self-checking testbench for the JSON string unescaper with UTF-8 output.
`timescale 1ns / 100ps

module tb_json_string_unescape_utf8
    import jsu_pkg::*;
();

    localparam int STALL_LIMIT  = 5000;
    localparam int RANDOM_ITEMS = 310;
    localparam int IDLE_PCT     = 7;

    typedef struct packed {
        logic [15:0] length;
        logic [7:0]  data;
        t_status     status;
        logic        has_byte;
        logic        last;
    } beat_t;

    typedef struct packed {
        logic [7:0]  txt;
        logic        known;
        t_status     st;
        logic [15:0] len;
    } stim_row_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [7:0]  i_s_axis_tdata = 8'd0;  // [7:0] in_byte
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [23:0] o_m_axis_tdata;         // [7:0] out_byte, [23:8] string_length
    logic [3:0]  o_m_axis_tuser;         // [0] has_byte, [3:1] status
    logic        o_m_axis_tlast;

    // Side information that travels with the byte on the input beat.
    logic        row_known = 1'b0;
    t_status     row_status = ST_DATA;
    logic [15:0] row_len = 16'd0;

    bit          calm = 1'b0;
    int          sent = 0;
    int          mismatches = 0;
    int          quiet = 0;

    // Decoder state mirrored by the predictor.
    t_mode                  p_mode = MODE_IDLE;
    logic [15:0]            p_hex = 16'd0;
    logic [1:0]             p_digits = 2'd0;
    logic [9:0]             p_hi = 10'd0;
    logic [LENGTH_BITS-1:0] p_count = '0;

    beat_t step_q[$];
    beat_t want_q[$];

    // Directed text: closing quotes and errors carry their expected beat.
    stim_row_t script [40] = '{
        '{8'hFF, 1'b1, ST_NOT_STRING, 16'd0},
        '{8'h00, 1'b1, ST_NOT_STRING, 16'd0},
        '{8'h22, 1'b0, ST_DATA,       16'd0},
        '{8'h22, 1'b1, ST_END,        16'd0},
        '{8'h22, 1'b0, ST_DATA,       16'd0},
        '{8'h00, 1'b1, ST_NO_QUOTE,   16'd0},
        '{8'h22, 1'b0, ST_DATA,       16'd0},
        '{8'h1F, 1'b1, ST_BAD_CHAR,   16'd0},
        '{8'h22, 1'b0, ST_DATA,       16'd0},
        '{8'h80, 1'b0, ST_DATA,       16'd0},
        '{8'hFF, 1'b0, ST_DATA,       16'd0},
        '{8'h5C, 1'b0, ST_DATA,       16'd0},
        '{8'h75, 1'b0, ST_DATA,       16'd0},
        '{8'h44, 1'b0, ST_DATA,       16'd0},
        '{8'h38, 1'b0, ST_DATA,       16'd0},
        '{8'h33, 1'b0, ST_DATA,       16'd0},
        '{8'h64, 1'b0, ST_DATA,       16'd0},
        '{8'h5C, 1'b0, ST_DATA,       16'd0},
        '{8'h75, 1'b0, ST_DATA,       16'd0},
        '{8'h44, 1'b0, ST_DATA,       16'd0},
        '{8'h45, 1'b0, ST_DATA,       16'd0},
        '{8'h30, 1'b0, ST_DATA,       16'd0},
        '{8'h30, 1'b0, ST_DATA,       16'd0},
        '{8'h1F, 1'b1, ST_BAD_CHAR,   16'd0},
        '{8'h22, 1'b0, ST_DATA,       16'd0},
        '{8'h5C, 1'b0, ST_DATA,       16'd0},
        '{8'h00, 1'b1, ST_BAD_ESC,    16'd0},
        '{8'h22, 1'b0, ST_DATA,       16'd0},
        '{8'h5C, 1'b0, ST_DATA,       16'd0},
        '{8'h75, 1'b0, ST_DATA,       16'd0},
        '{8'h30, 1'b0, ST_DATA,       16'd0},
        '{8'h00, 1'b1, ST_BAD_HEX,    16'd0},
        '{8'h22, 1'b0, ST_DATA,       16'd0},
        '{8'h5C, 1'b0, ST_DATA,       16'd0},
        '{8'h75, 1'b0, ST_DATA,       16'd0},
        '{8'h44, 1'b0, ST_DATA,       16'd0},
        '{8'h42, 1'b0, ST_DATA,       16'd0},
        '{8'h46, 1'b0, ST_DATA,       16'd0},
        '{8'h46, 1'b0, ST_DATA,       16'd0},
        '{8'h41, 1'b1, ST_BAD_SURR,   16'd0}
    };

    json_string_unescape_utf8 DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic void put_data(input logic [7:0] b);
        step_q.push_back('{length: 16'd0, data: b, status: ST_DATA, has_byte: 1'b1,
                           last: 1'b0});
        if (p_count != {LENGTH_BITS{1'b1}}) begin
            p_count++;
        end
    endfunction

    function automatic void put_end(input t_status st, input logic [15:0] len);
        step_q.push_back('{length: len, data: 8'd0, status: st, has_byte: 1'b0,
                           last: 1'b0});
        p_mode = MODE_IDLE;
    endfunction

    // Advance the decoder by one text byte; leave its beats in step_q.
    function automatic void unescape_step(input logic [7:0] c);
        logic [3:0]  nib;
        bit          is_hex;
        logic [20:0] cp;
        step_q.delete();
        is_hex = 1'b1;
        nib = 4'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            nib = c[3:0];
        end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
            nib = c[3:0] + 4'd9;
        end else begin
            is_hex = 1'b0;
        end
        case (p_mode)
            MODE_TEXT: begin
                if (c == CH_QUOTE) begin
                    put_end(ST_END, p_count[15:0]);
                end else if (c == CH_NUL) begin
                    put_end(ST_NO_QUOTE, 16'd0);
                end else if (c == CH_BSLSH) begin
                    p_mode = MODE_ESC;
                end else if (c < CH_SPACE) begin
                    put_end(ST_BAD_CHAR, 16'd0);
                end else begin
                    put_data(c);
                end
            end
            MODE_ESC: begin
                p_mode = MODE_TEXT;
                case (c)
                    CH_QUOTE, CH_BSLSH, CH_SLASH: put_data(c);
                    CH_LO_B: put_data(8'h08);
                    CH_LO_F: put_data(8'h0C);
                    CH_LO_N: put_data(8'h0A);
                    CH_LO_R: put_data(8'h0D);
                    CH_LO_T: put_data(8'h09);
                    CH_LO_U: begin
                        p_mode = MODE_HEX;
                        p_hex = 16'd0;
                        p_digits = 2'd0;
                    end
                    default: put_end(ST_BAD_ESC, 16'd0);
                endcase
            end
            MODE_HEX, MODE_LOW_HEX: begin
                if (!is_hex) begin
                    put_end(ST_BAD_HEX, 16'd0);
                end else begin
                    p_hex = {p_hex[11:0], nib};
                    if (p_digits != 2'd3) begin
                        p_digits++;
                    end else begin
                        p_digits = 2'd0;
                        cp = {5'd0, p_hex};
                        if (p_mode == MODE_HEX && p_hex >= HI_SURR_MIN
                                && p_hex <= HI_SURR_MAX) begin
                            // hold the high half until the low escape arrives
                            p_hi = p_hex[9:0];
                            p_mode = MODE_LOW_BS;
                        end else if (p_mode == MODE_LOW_HEX && (p_hex < LO_SURR_MIN
                                || p_hex > LO_SURR_MAX)) begin
                            put_end(ST_BAD_SURR, 16'd0);
                        end else begin
                            if (p_mode == MODE_LOW_HEX) begin
                                cp = {1'b0, p_hi, p_hex[9:0]} + SUPP_BASE;
                            end
                            p_mode = MODE_TEXT;
                            if (cp <= 21'h7F) begin
                                put_data(cp[7:0]);
                            end else if (cp <= 21'h7FF) begin
                                put_data({3'b110, cp[10:6]});
                                put_data({2'b10, cp[5:0]});
                            end else if (cp <= 21'hFFFF) begin
                                put_data({4'b1110, cp[15:12]});
                                put_data({2'b10, cp[11:6]});
                                put_data({2'b10, cp[5:0]});
                            end else begin
                                put_data({5'b11110, cp[20:18]});
                                put_data({2'b10, cp[17:12]});
                                put_data({2'b10, cp[11:6]});
                                put_data({2'b10, cp[5:0]});
                            end
                        end
                    end
                end
            end
            MODE_LOW_BS: begin
                if (c == CH_BSLSH) begin
                    p_mode = MODE_LOW_U;
                end else begin
                    put_end(ST_BAD_SURR, 16'd0);
                end
            end
            MODE_LOW_U: begin
                if (c == CH_LO_U) begin
                    p_mode = MODE_LOW_HEX;
                    p_hex = 16'd0;
                    p_digits = 2'd0;
                end else begin
                    put_end(ST_BAD_SURR, 16'd0);
                end
            end
            default: begin
                p_mode = MODE_IDLE;
                if (c == CH_QUOTE) begin
                    p_mode = MODE_TEXT;
                    p_count = '0;
                    p_hex = 16'd0;
                    p_digits = 2'd0;
                end else begin
                    put_end(ST_NOT_STRING, 16'd0);
                end
            end
        endcase
        if (step_q.size() != 0) begin
            step_q[step_q.size() - 1].last = 1'b1;
        end
    endfunction

    function automatic void log_mismatch(input string what, input beat_t want,
                                         input beat_t got);
        mismatches++;
        if (mismatches <= 10) begin
            $display("%0t %s: want byte %02h has %0d st %0d len %0d last %0d", $time,
                     what, want.data, want.has_byte, want.status, want.length, want.last);
            $display("%0t %s: got  byte %02h has %0d st %0d len %0d last %0d", $time,
                     what, got.data, got.has_byte, got.status, got.length, got.last);
        end
    endfunction

    // Predict on input beats first, then check output beats against the oldest entry.
    always @(posedge i_clk) begin : monitor
        beat_t got;
        if (!i_rst_n) begin
            p_mode = MODE_IDLE;
            p_hex = 16'd0;
            p_digits = 2'd0;
            p_hi = 10'd0;
            p_count = '0;
            want_q.delete();
        end else begin
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                unescape_step(i_s_axis_tdata);
                if (row_known) begin
                    want_q.push_back('{length: row_len, data: 8'd0, status: row_status,
                                       has_byte: 1'b0, last: 1'b1});
                end else begin
                    foreach (step_q[k]) want_q.push_back(step_q[k]);
                end
            end
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                got.data     = o_m_axis_tdata[7:0];
                got.length   = o_m_axis_tdata[23:8];
                got.has_byte = o_m_axis_tuser[0];
                got.status   = t_status'(o_m_axis_tuser[3:1]);
                got.last     = o_m_axis_tlast;
                if (want_q.size() == 0) begin
                    log_mismatch("unexpected beat", '0, got);
                end else if (got !== want_q[0]) begin
                    log_mismatch("mismatch", want_q.pop_front(), got);
                end else begin
                    void'(want_q.pop_front());
                end
            end
        end
    end

    always @(posedge i_clk) begin
        i_m_axis_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_axis_tvalid && o_s_axis_tready)
                || (o_m_axis_tvalid && i_m_axis_tready)) begin
            quiet <= 0;
        end else if (quiet >= STALL_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

    task automatic push_byte(input logic [7:0] b, input logic known = 1'b0,
                             input t_status st = ST_DATA, input logic [15:0] len = 16'd0);
        while (!calm && $urandom_range(99) < IDLE_PCT) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= b;
        row_known       <= known;
        row_status      <= st;
        row_len         <= len;
        do @(posedge i_clk); while (!o_s_axis_tready);
        sent++;
    endtask

    // Hold the sender until every predicted beat has drained.
    task automatic drain_results();
        i_s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (want_q.size() != 0);
    endtask

    function automatic logic [7:0] hex_char(input logic [3:0] n, input bit upper);
        if (n < 4'd10) begin
            return 8'h30 + n;
        end
        return (upper ? 8'h37 : 8'h57) + n;
    endfunction

    function automatic logic [7:0] text_byte();
        logic [7:0] b;
        do b = 8'($urandom_range(8'hFF, 8'h20)); while (b == CH_QUOTE || b == CH_BSLSH);
        return b;
    endfunction

    task automatic push_u_escape(input logic [15:0] v);
        push_byte(CH_BSLSH);
        push_byte(CH_LO_U);
        for (int i = 3; i >= 0; i--) begin
            push_byte(hex_char(v[4*i +: 4], 1'($urandom_range(1))));
        end
    endtask

    // One string with random content, mostly closed, sometimes broken.
    task automatic send_random_string();
        logic [7:0]  escs [8] = '{CH_QUOTE, CH_BSLSH, CH_SLASH, CH_LO_B,
                                  CH_LO_F, CH_LO_N, CH_LO_R, CH_LO_T};
        logic [7:0]  b;
        logic [15:0] v;
        int          segs;
        int          n;
        segs = $urandom_range(6);
        push_byte(CH_QUOTE);
        repeat (segs) begin
            case ($urandom_range(9))
                0, 1, 2, 3: push_byte(text_byte());
                4, 5: begin
                    push_byte(CH_BSLSH);
                    push_byte(escs[$urandom_range(7)]);
                end
                6: begin
                    case ($urandom_range(3))
                        0: v = 16'($urandom_range(16'h007F, 16'h0000));
                        1: v = 16'($urandom_range(16'h07FF, 16'h0080));
                        2: v = 16'($urandom_range(16'hD7FF, 16'h0800));
                        default: v = 16'($urandom_range(16'hFFFF, 16'hE000));
                    endcase
                    push_u_escape(v);
                end
                7: begin
                    push_u_escape(16'($urandom_range(HI_SURR_MAX, HI_SURR_MIN)));
                    push_u_escape(16'($urandom_range(LO_SURR_MAX, LO_SURR_MIN)));
                end
                8: push_u_escape(16'($urandom_range(LO_SURR_MAX, LO_SURR_MIN)));
                default: push_byte(8'($urandom_range(8'hFF, 8'h80)));
            endcase
        end
        case ($urandom_range(19))
            13: push_byte(CH_NUL);
            14: push_byte(8'($urandom_range(8'h1F, 8'h01)));
            15: begin
                push_byte(CH_BSLSH);
                if ($urandom_range(3) == 0) begin
                    b = CH_NUL;
                end else begin
                    do b = 8'($urandom_range(255));
                    while (b == CH_QUOTE || b == CH_BSLSH || b == CH_SLASH || b == CH_LO_B
                           || b == CH_LO_F || b == CH_LO_N || b == CH_LO_R
                           || b == CH_LO_T || b == CH_LO_U);
                end
                push_byte(b);
            end
            16: begin
                push_byte(CH_BSLSH);
                push_byte(CH_LO_U);
                n = $urandom_range(3);
                repeat (n) begin
                    push_byte(hex_char(4'($urandom_range(15)), 1'($urandom_range(1))));
                end
                if ($urandom_range(3) == 0) begin
                    b = CH_NUL;
                end else begin
                    do b = 8'($urandom_range(255));
                    while ((b >= 8'h30 && b <= 8'h39) || (b >= 8'h41 && b <= 8'h46)
                           || (b >= 8'h61 && b <= 8'h66));
                end
                push_byte(b);
            end
            17: begin
                push_u_escape(16'($urandom_range(HI_SURR_MAX, HI_SURR_MIN)));
                do b = 8'($urandom_range(255)); while (b == CH_BSLSH);
                push_byte(b);
            end
            18: begin
                push_u_escape(16'($urandom_range(HI_SURR_MAX, HI_SURR_MIN)));
                push_byte(CH_BSLSH);
                do b = 8'($urandom_range(255)); while (b == CH_LO_U);
                push_byte(b);
            end
            19: begin
                push_u_escape(16'($urandom_range(HI_SURR_MAX, HI_SURR_MIN)));
                do v = 16'($urandom); while (v >= LO_SURR_MIN && v <= LO_SURR_MAX);
                push_u_escape(v);
            end
            default: push_byte(CH_QUOTE);
        endcase
    endtask

    initial begin : stimulus
        logic [7:0] b;
        int         base;
        int         n;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (script[k]) begin
            push_byte(script[k].txt, script[k].known, script[k].st, script[k].len);
        end
        drain_results();

        base = sent;
        while (sent < base + RANDOM_ITEMS) begin
            calm = (sent >= base + 120) && (sent < base + 220);
            // stray bytes between strings
            if ($urandom_range(99) < 15) begin
                n = $urandom_range(3, 1);
                repeat (n) begin
                    do b = 8'($urandom_range(255)); while (b == CH_QUOTE);
                    push_byte(b);
                end
            end
            send_random_string();
            if ($urandom_range(99) < 5) begin
                drain_results();
            end
        end
        calm = 1'b0;
        drain_results();

        repeat (16) @(posedge i_clk);
        mismatches += want_q.size();
        if (mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/jsu_pkg.sv
rtl/json_string_unescape_utf8.sv
tb/sv/tb_json_string_unescape_utf8.sv
